@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL modules of the LRU page replacement block.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every sampled clock edge out of reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// The consequent must hold whenever the antecedent holds.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/lrupr_pkg.sv @@
// Package for the LRU page replacement block: sizes, state encoding and result type.
// Used by lrupr_ctrl and lru_page_replacement; no dependencies.
package lrupr_pkg;

  localparam int MAX_FRAMES = 8;
  localparam int PAGE_BITS  = 8;

  localparam int IDX_W   = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CNT_W   = $clog2(MAX_FRAMES + 1);
  localparam int PAGE_W  = 8;
  localparam int FAULT_W = 16;
  localparam int CFG_W   = 4;
  localparam int RES_W   = 4;

  localparam logic [CFG_W-1:0]   FRAME_COUNT_RST = CFG_W'(3);
  localparam logic [FAULT_W-1:0] FAULT_MAX       = '1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EVICT,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic               fault;
    logic [FAULT_W-1:0] fault_count;
    logic               evicted_valid;
    logic [PAGE_W-1:0]  evicted_page;
    logic [RES_W-1:0]   resident_count;
  } result_t;

endpackage

@@ rtl/lrupr_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module lrupr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                     clk_i,
  input  logic                                     wr_en_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]                         wr_data_i,
  input  logic                                     rd_en_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]                         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ rtl/lrupr_ctrl.sv @@
// Sequencer for the LRU page replacement block: scans the recency list in RAM,
// shifts entries down and writes the referenced page back. Depends on lrupr_pkg.
`include "assert_macros.svh"

module lrupr_ctrl (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [lrupr_pkg::PAGE_W-1:0]    page_i,
  input  logic                            clear_first_i,
  input  logic [lrupr_pkg::CNT_W-1:0]     limit_i,
  input  logic                            out_free_i,
  output logic                            res_valid_o,
  output lrupr_pkg::result_t              res_o,
  output logic                            ram_rd_en_o,
  output logic [lrupr_pkg::IDX_W-1:0]     ram_rd_addr_o,
  input  logic [lrupr_pkg::PAGE_BITS-1:0] ram_rd_data_i,
  output logic                            ram_wr_en_o,
  output logic [lrupr_pkg::IDX_W-1:0]     ram_wr_addr_o,
  output logic [lrupr_pkg::PAGE_BITS-1:0] ram_wr_data_o
);
  import lrupr_pkg::*;

  state_e               state_q, state_d;
  logic [PAGE_BITS-1:0] pg_q, pg_d;
  logic [CNT_W-1:0]     occ_q, occ_d;
  logic [FAULT_W-1:0]   faults_q, faults_d;
  logic [CNT_W-1:0]     rd_idx_q, rd_idx_d;
  logic                 pend_q, pend_d;
  logic [IDX_W-1:0]     pend_idx_q, pend_idx_d;
  logic                 found_q, found_d;
  logic                 ev_q, ev_d;
  logic [PAGE_BITS-1:0] ev_page_q, ev_page_d;

  logic accept;
  logic issue;
  logic pass_done;

  assign accept    = in_valid_i && in_ready_o;
  assign issue     = ((state_q == ST_SCAN) || (state_q == ST_EVICT)) && (rd_idx_q < occ_q);
  assign pass_done = !issue && !pend_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (pass_done) begin
          if (found_q || (occ_q < limit_i)) begin
            state_d = ST_FINISH;
          end else begin
            state_d = ST_EVICT;
          end
        end
      end
      ST_EVICT: begin
        if (pass_done) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o    = (state_q == ST_IDLE);
    pg_d          = pg_q;
    occ_d         = occ_q;
    faults_d      = faults_q;
    rd_idx_d      = rd_idx_q;
    pend_d        = 1'b0;
    pend_idx_d    = pend_idx_q;
    found_d       = found_q;
    ev_d          = ev_q;
    ev_page_d     = ev_page_q;
    ram_rd_en_o   = issue;
    ram_rd_addr_o = rd_idx_q[IDX_W-1:0];
    ram_wr_en_o   = 1'b0;
    ram_wr_addr_o = pend_idx_q - IDX_W'(1);
    ram_wr_data_o = ram_rd_data_i;
    res_valid_o   = 1'b0;

    if (issue) begin
      rd_idx_d   = rd_idx_q + CNT_W'(1);
      pend_d     = 1'b1;
      pend_idx_d = rd_idx_q[IDX_W-1:0];
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          pg_d      = page_i[PAGE_BITS-1:0];
          rd_idx_d  = '0;
          found_d   = 1'b0;
          ev_d      = 1'b0;
          ev_page_d = '0;
          if (clear_first_i) begin
            occ_d    = '0;
            faults_d = '0;
          end
        end
      end
      ST_SCAN: begin
        if (pend_q) begin
          if (!found_q && (ram_rd_data_i == pg_q)) begin
            found_d = 1'b1;
          end else if (found_q) begin
            ram_wr_en_o = 1'b1;
          end
        end
        if (pass_done) begin
          rd_idx_d = '0;
        end
      end
      ST_EVICT: begin
        if (pend_q) begin
          if (pend_idx_q == '0) begin
            ev_d      = 1'b1;
            ev_page_d = ram_rd_data_i;
          end else begin
            ram_wr_en_o = 1'b1;
          end
        end
      end
      ST_FINISH: begin
        if (out_free_i) begin
          ram_wr_en_o   = 1'b1;
          ram_wr_data_o = pg_q;
          res_valid_o   = 1'b1;
          if (found_q || ev_q) begin
            ram_wr_addr_o = occ_q[IDX_W-1:0] - IDX_W'(1);
          end else begin
            ram_wr_addr_o = occ_q[IDX_W-1:0];
            occ_d         = occ_q + CNT_W'(1);
          end
          if (!found_q && (faults_q != FAULT_MAX)) begin
            faults_d = faults_q + FAULT_W'(1);
          end
        end
      end
      default: ;
    endcase

    res_o.fault          = !found_q;
    res_o.fault_count    = faults_d;
    res_o.evicted_valid  = ev_q;
    res_o.evicted_page   = PAGE_W'(ev_page_q);
    res_o.resident_count = RES_W'(occ_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      occ_q      <= '0;
      faults_q   <= '0;
      rd_idx_q   <= '0;
      pend_q     <= 1'b0;
      pend_idx_q <= '0;
      found_q    <= 1'b0;
      ev_q       <= 1'b0;
    end else begin
      state_q    <= state_d;
      occ_q      <= occ_d;
      faults_q   <= faults_d;
      rd_idx_q   <= rd_idx_d;
      pend_q     <= pend_d;
      pend_idx_q <= pend_idx_d;
      found_q    <= found_d;
      ev_q       <= ev_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pg_q      <= pg_d;
    ev_page_q <= ev_page_d;
  end

  `ASSERT_ALWAYS(a_occ_bound, occ_q <= CNT_W'(MAX_FRAMES), "occupancy exceeds frame depth")
  `ASSERT_IMPLIES(a_shift_below_read, ram_wr_en_o && (state_q != ST_FINISH), ram_wr_addr_o < pend_idx_q, "shift write not below entry just read")
  `ASSERT_NEXT(a_result_ends_item, res_valid_o, (state_q == ST_IDLE) && (occ_q >= $past(occ_q)), "result not followed by idle")

endmodule

@@ rtl/lru_page_replacement.sv @@
// Top level of the LRU page replacement block: frame count register, output
// register and the sequencer with its recency list RAM. Depends on lrupr_pkg.
//
//   channel  direction  handshake               payload
//   cfg      in         cfg_valid_i/cfg_ready_o cfg_data_i (frame count)
//   in       in         in_valid_i/in_ready_o   page_i, clear_first_i
//   out      out        out_valid_o/out_ready_i fault_o .. resident_count_o
//
// From acceptance to a valid result, a hit or a miss with a free frame takes one pass
// over the recency list RAM and a miss on full frames takes two, as the RAM is read
// once per entry per pass.
// The next item is accepted in the cycle after the result at the earliest.
// Reset empties the frames, zeroes the fault count and loads a frame count of three.
// A finished item waits in the output register; the next item is taken meanwhile and
// stalls only at its final write if the previous result has not been taken.
`include "assert_macros.svh"

module lru_page_replacement (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [lrupr_pkg::CFG_W-1:0]   cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [lrupr_pkg::PAGE_W-1:0]  page_i,
  input  logic                          clear_first_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          fault_o,
  output logic [lrupr_pkg::FAULT_W-1:0] fault_count_o,
  output logic                          evicted_valid_o,
  output logic [lrupr_pkg::PAGE_W-1:0]  evicted_page_o,
  output logic [lrupr_pkg::RES_W-1:0]   resident_count_o
);
  import lrupr_pkg::*;

  logic [CFG_W-1:0]     frame_count_q, frame_count_d;
  logic [CNT_W-1:0]     limit;
  logic                 out_valid_q, out_valid_d;
  result_t              out_q, out_d;
  logic                 out_free;
  logic                 res_valid;
  result_t              res;
  logic                 ram_rd_en;
  logic [IDX_W-1:0]     ram_rd_addr;
  logic [PAGE_BITS-1:0] ram_rd_data;
  logic                 ram_wr_en;
  logic [IDX_W-1:0]     ram_wr_addr;
  logic [PAGE_BITS-1:0] ram_wr_data;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    frame_count_d = frame_count_q;
    if (cfg_valid_i && cfg_ready_o) begin
      frame_count_d = cfg_data_i;
    end
    if (frame_count_q == '0) begin
      limit = CNT_W'(1);
    end else if (int'(frame_count_q) > MAX_FRAMES) begin
      limit = CNT_W'(MAX_FRAMES);
    end else begin
      limit = CNT_W'(frame_count_q);
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (res_valid) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_count_q <= FRAME_COUNT_RST;
      out_valid_q   <= 1'b0;
    end else begin
      frame_count_q <= frame_count_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  lrupr_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .page_i        (page_i),
    .clear_first_i (clear_first_i),
    .limit_i       (limit),
    .out_free_i    (out_free),
    .res_valid_o   (res_valid),
    .res_o         (res),
    .ram_rd_en_o   (ram_rd_en),
    .ram_rd_addr_o (ram_rd_addr),
    .ram_rd_data_i (ram_rd_data),
    .ram_wr_en_o   (ram_wr_en),
    .ram_wr_addr_o (ram_wr_addr),
    .ram_wr_data_o (ram_wr_data)
  );

  lrupr_ram #(
    .WIDTH (PAGE_BITS),
    .DEPTH (MAX_FRAMES)
  ) u_recency_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_wr_en),
    .wr_addr_i (ram_wr_addr),
    .wr_data_i (ram_wr_data),
    .rd_en_i   (ram_rd_en),
    .rd_addr_i (ram_rd_addr),
    .rd_data_o (ram_rd_data)
  );

  assign out_valid_o      = out_valid_q;
  assign fault_o          = out_q.fault;
  assign fault_count_o    = out_q.fault_count;
  assign evicted_valid_o  = out_q.evicted_valid;
  assign evicted_page_o   = out_q.evicted_page;
  assign resident_count_o = out_q.resident_count;

  `ASSERT_IMPLIES(a_no_result_overwrite, out_valid_q && !out_ready_i, !res_valid, "result overwrites pending item")
  `ASSERT_IMPLIES(a_hit_no_evict, out_valid_o && !fault_o, !evicted_valid_o, "hit reports an eviction")
  `ASSERT_IMPLIES(a_evict_page_zero, out_valid_o && !evicted_valid_o, evicted_page_o == '0, "evicted page nonzero without eviction")

endmodule
